FILE: design/lpqs_pkg.sv
// lpqs_pkg: shared types and constants of the led pattern queue sequencer
// no dependencies; used by lpqs_front, lpqs_back and the top level
`timescale 1ns / 1ps

package lpqs_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int TICK_W     = 16;
  localparam int REP_IN_W   = 16;
  localparam int CODE_W     = 3;
  localparam int COUNT_OUT_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_TICKS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_OFF_TICKS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ONCE_OFF_TICKS = 2'd3;

  localparam logic              RST_ACTIVE_LEVEL   = 1'b1;
  localparam logic [TICK_W-1:0] RST_ON_TICKS       = 16'd10;
  localparam logic [TICK_W-1:0] RST_SLOW_OFF_TICKS = 16'd190;
  localparam logic [TICK_W-1:0] RST_ONCE_OFF_TICKS = 16'd40;

  localparam logic [CODE_W-1:0] ACT_OFF   = 3'd0;
  localparam logic [CODE_W-1:0] ACT_SLOW  = 3'd1;
  localparam logic [CODE_W-1:0] ACT_ANGRY = 3'd2;
  localparam logic [CODE_W-1:0] ACT_ONCE  = 3'd3;
  localparam logic [CODE_W-1:0] ACT_ON    = 3'd4;

  typedef enum logic [0:0] {
    CMD_TICK = 1'b0,
    CMD_PUSH = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                   kind;
    logic [CODE_W-1:0]           action_code;
    logic signed [REP_IN_W-1:0]  repeat_count;
  } cmd_t;

endpackage

FILE: design/lpqs_ram.sv
// lpqs_ram: generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module lpqs_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/lpqs_front.sv
// lpqs_front: accepts requests, classifies them as tick or push and
// buffers them in a two-entry command queue; depends on lpqs_pkg
`timescale 1ns / 1ps

module lpqs_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               req_type_i,
  input  logic [lpqs_pkg::CODE_W-1:0]        action_code_i,
  input  logic signed [lpqs_pkg::REP_IN_W-1:0] repeat_count_i,
  output logic                               cmd_valid_o,
  output lpqs_pkg::cmd_t                     cmd_o,
  input  logic                               cmd_pop_i
);

  lpqs_pkg::cmd_t buf_q [2];
  lpqs_pkg::cmd_t cmd_in;
  logic           wr_q, wr_d;
  logic           rd_q, rd_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push;
  logic           pop;

  always_comb begin
    cmd_in.kind         = req_type_i ? lpqs_pkg::CMD_PUSH : lpqs_pkg::CMD_TICK;
    cmd_in.action_code  = action_code_i;
    cmd_in.repeat_count = repeat_count_i;
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = buf_q[rd_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = pop ? !rd_q : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= cmd_in;
    end
  end

endmodule

FILE: design/lpqs_back.sv
// lpqs_back: action queue bookkeeping, blink sequencer, config registers
// and result register; depends on lpqs_pkg and lpqs_ram
`timescale 1ns / 1ps

module lpqs_back #(
  parameter int QUEUE_DEPTH = 8,
  parameter int REPEAT_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lpqs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lpqs_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 cmd_valid_i,
  input  lpqs_pkg::cmd_t                       cmd_i,
  output logic                                 cmd_pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 led_level_o,
  output logic [lpqs_pkg::COUNT_OUT_W-1:0]     queue_count_o,
  output logic                                 pattern_active_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int RW = (REPEAT_BITS > lpqs_pkg::REP_IN_W) ? REPEAT_BITS : lpqs_pkg::REP_IN_W;
  localparam int DW = lpqs_pkg::CODE_W + REPEAT_BITS;
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);
  localparam logic signed [RW-1:0] RMAX =
    {{(RW - REPEAT_BITS + 1){1'b0}}, {(REPEAT_BITS - 1){1'b1}}};
  localparam logic signed [RW-1:0] RMIN = ~RMAX;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SKIP,
    ST_ADV
  } state_e;

  state_e                    state_q, state_d;
  logic [PW-1:0]             rptr_q, rptr_d;
  logic [PW-1:0]             wptr_q, wptr_d;
  logic [CW-1:0]             count_q, count_d;
  logic                      restart_q, restart_d;
  logic                      run_valid_q, run_valid_d;
  logic [PW-1:0]             run_slot_q, run_slot_d;
  logic                      phase_q, phase_d;
  logic [lpqs_pkg::TICK_W-1:0] ticks_q, ticks_d;
  logic                      hold_q, hold_d;
  logic                      pin_q, pin_d;

  logic                      active_q;
  logic [lpqs_pkg::TICK_W-1:0] on_ticks_q;
  logic [lpqs_pkg::TICK_W-1:0] slow_off_q;
  logic [lpqs_pkg::TICK_W-1:0] once_off_q;

  logic                      out_valid_q, out_valid_d;
  logic                      led_q;
  logic [lpqs_pkg::COUNT_OUT_W-1:0] cnt_ext_q;
  logic                      act_q;

  logic                      ram_we;
  logic [PW-1:0]             ram_waddr;
  logic [DW-1:0]             ram_wdata;
  logic [PW-1:0]             ram_raddr;
  logic [DW-1:0]             ram_rdata;

  logic [lpqs_pkg::CODE_W-1:0] rd_code;
  logic signed [REPEAT_BITS-1:0] rd_rep;
  logic signed [RW-1:0]      raw_ext;
  logic signed [REPEAT_BITS-1:0] rep_clamped;

  logic                      out_free;
  logic                      finish;
  logic                      stop, lit, hold;
  logic [lpqs_pkg::TICK_W-1:0] dur;
  logic                      nphase;

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    next_slot = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  lpqs_ram #(
    .WIDTH (DW),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_code = ram_rdata[DW-1 -: lpqs_pkg::CODE_W];
  assign rd_rep  = signed'(ram_rdata[REPEAT_BITS-1:0]);

  // saturate the pushed repeat count to the stored width
  always_comb begin
    raw_ext = RW'(cmd_i.repeat_count);
    if (raw_ext > RMAX) begin
      rep_clamped = REPEAT_BITS'(RMAX);
    end else if (raw_ext < RMIN) begin
      rep_clamped = REPEAT_BITS'(RMIN);
    end else begin
      rep_clamped = REPEAT_BITS'(raw_ext);
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    rptr_d      = rptr_q;
    wptr_d      = wptr_q;
    count_d     = count_q;
    restart_d   = restart_q;
    run_valid_d = run_valid_q;
    run_slot_d  = run_slot_q;
    phase_d     = phase_q;
    ticks_d     = ticks_q;
    hold_d      = hold_q;
    pin_d       = pin_q;
    ram_we      = 1'b0;
    ram_waddr   = wptr_q;
    ram_wdata   = {cmd_i.action_code, rep_clamped};
    ram_raddr   = rptr_q;
    cmd_pop_o   = 1'b0;
    finish      = 1'b0;
    stop        = 1'b0;
    lit         = 1'b0;
    hold        = 1'b0;
    dur         = '0;
    nphase      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == lpqs_pkg::CMD_PUSH) begin
            ram_we    = 1'b1;
            wptr_d    = next_slot(wptr_q);
            if (count_q != FULL) begin
              count_d = count_q + CW'(1);
            end else begin
              rptr_d      = next_slot(rptr_q);
              run_valid_d = 1'b0;
            end
            restart_d = 1'b1;
            finish    = 1'b1;
          end else if (restart_q) begin
            if (count_q == '0) begin
              finish = 1'b1;
            end else begin
              ram_raddr = rptr_q;
              state_d   = ST_SKIP;
            end
          end else if (run_valid_q && !hold_q) begin
            if (ticks_q < lpqs_pkg::TICK_W'(2)) begin
              ram_raddr = run_slot_q;
              state_d   = ST_ADV;
            end else begin
              ticks_d = ticks_q - lpqs_pkg::TICK_W'(1);
              finish  = 1'b1;
            end
          end else begin
            finish = 1'b1;
          end
        end
      end

      // drop leading forever entries while more follow
      ST_SKIP: begin
        if (count_q > CW'(1) && rd_rep[REPEAT_BITS-1]) begin
          count_d   = count_q - CW'(1);
          rptr_d    = next_slot(rptr_q);
          ram_raddr = next_slot(rptr_q);
        end else begin
          run_slot_d  = rptr_q;
          run_valid_d = 1'b1;
          phase_d     = 1'b0;
          ram_raddr   = rptr_q;
          state_d     = ST_ADV;
        end
      end

      ST_ADV: begin
        unique case (rd_code)
          lpqs_pkg::ACT_OFF: begin
            hold = 1'b1;
          end
          lpqs_pkg::ACT_ON: begin
            lit  = 1'b1;
            hold = 1'b1;
          end
          lpqs_pkg::ACT_SLOW, lpqs_pkg::ACT_ANGRY, lpqs_pkg::ACT_ONCE: begin
            if (phase_q) begin
              if (rd_code == lpqs_pkg::ACT_SLOW) begin
                dur = slow_off_q;
              end else if (rd_code == lpqs_pkg::ACT_ANGRY) begin
                dur = on_ticks_q;
              end else begin
                dur = once_off_q;
              end
              if (!rd_rep[REPEAT_BITS-1]) begin
                ram_we    = 1'b1;
                ram_waddr = run_slot_q;
                ram_wdata = {rd_code, rd_rep - REPEAT_BITS'(1)};
                stop      = (rd_rep == '0);
              end
            end else begin
              lit    = 1'b1;
              dur    = on_ticks_q;
              nphase = 1'b1;
            end
          end
          default: begin
            if (count_q != '0) begin
              stop    = 1'b1;
              rptr_d  = next_slot(rptr_q);
              count_d = count_q - CW'(1);
            end else begin
              hold = 1'b1;
            end
          end
        endcase

        restart_d = stop;
        if (stop) begin
          run_valid_d = 1'b0;
        end else begin
          ticks_d = dur;
          phase_d = nphase;
          hold_d  = hold;
          pin_d   = lit ? active_q : !active_q;
        end
        finish  = 1'b1;
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rptr_q      <= '0;
      wptr_q      <= '0;
      count_q     <= '0;
      restart_q   <= 1'b0;
      run_valid_q <= 1'b0;
      run_slot_q  <= '0;
      phase_q     <= 1'b0;
      ticks_q     <= '0;
      hold_q      <= 1'b0;
      pin_q       <= !lpqs_pkg::RST_ACTIVE_LEVEL;
      out_valid_q <= 1'b0;
      led_q       <= !lpqs_pkg::RST_ACTIVE_LEVEL;
      cnt_ext_q   <= '0;
      act_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      rptr_q      <= rptr_d;
      wptr_q      <= wptr_d;
      count_q     <= count_d;
      restart_q   <= restart_d;
      run_valid_q <= run_valid_d;
      run_slot_q  <= run_slot_d;
      phase_q     <= phase_d;
      ticks_q     <= ticks_d;
      hold_q      <= hold_d;
      pin_q       <= pin_d;
      out_valid_q <= out_valid_d;
      if (finish) begin
        led_q     <= pin_d;
        cnt_ext_q <= lpqs_pkg::COUNT_OUT_W'(count_d);
        act_q     <= run_valid_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= lpqs_pkg::RST_ACTIVE_LEVEL;
      on_ticks_q <= lpqs_pkg::RST_ON_TICKS;
      slow_off_q <= lpqs_pkg::RST_SLOW_OFF_TICKS;
      once_off_q <= lpqs_pkg::RST_ONCE_OFF_TICKS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lpqs_pkg::CFG_ACTIVE_LEVEL:   active_q   <= cfg_wdata_i[0];
        lpqs_pkg::CFG_ON_TICKS:       on_ticks_q <= cfg_wdata_i;
        lpqs_pkg::CFG_SLOW_OFF_TICKS: slow_off_q <= cfg_wdata_i;
        lpqs_pkg::CFG_ONCE_OFF_TICKS: once_off_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign led_level_o      = led_q;
  assign queue_count_o    = cnt_ext_q;
  assign pattern_active_o = act_q;

endmodule

FILE: design/led_pattern_queue_sequencer.sv
// led_pattern_queue_sequencer: top level of the led pattern queue sequencer
// depends on lpqs_pkg, lpqs_front, lpqs_back and lpqs_ram
`timescale 1ns / 1ps

// Drives one LED pin from a ring queue of up to QUEUE_DEPTH blink actions.
// A request either pushes an action (code and repeat count) or is one time
// tick; every request returns one result with the pin level, the number of
// queued entries and whether an action runs. Requests pass through a
// two-entry command queue, then the sequencer takes one at a time: a push,
// a plain countdown tick and an idle tick are done in state ST_IDLE, a tick
// that moves the running action to its next phase goes on to ST_ADV
// (registered read of the entry ram), and a tick that restarts the run (the
// first tick after a push, a spent entry or a dropped unknown entry) goes
// through ST_SKIP, one ram read per leading forever entry dropped (at most
// QUEUE_DEPTH - 1), and then on to ST_ADV. Write the config registers
// only while no request is in flight.

module led_pattern_queue_sequencer #(
  parameter int QUEUE_DEPTH = 8,
  parameter int REPEAT_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lpqs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lpqs_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 req_type_i,
  input  logic [lpqs_pkg::CODE_W-1:0]          action_code_i,
  input  logic signed [lpqs_pkg::REP_IN_W-1:0] repeat_count_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 led_level_o,
  output logic [lpqs_pkg::COUNT_OUT_W-1:0]     queue_count_o,
  output logic                                 pattern_active_o
);

  logic           cmd_valid;
  lpqs_pkg::cmd_t cmd;
  logic           cmd_pop;

  lpqs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .action_code_i  (action_code_i),
    .repeat_count_i (repeat_count_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  lpqs_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .REPEAT_BITS (REPEAT_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .cmd_valid_i      (cmd_valid),
    .cmd_i            (cmd),
    .cmd_pop_o        (cmd_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .led_level_o      (led_level_o),
    .queue_count_o    (queue_count_o),
    .pattern_active_o (pattern_active_o)
  );

endmodule

FILE: bench/led_pattern_queue_sequencer_test.sv
// led_pattern_queue_sequencer_test: self-checking bench for the led pattern queue sequencer
// drives push and tick requests with random gaps and stalls, checks each status result
// against an in-bench copy of the sequencer; depends on lpqs_pkg and the top level
`timescale 1ns / 1ps

module led_pattern_queue_sequencer_test;
  import lpqs_pkg::*;

  localparam int DEPTH = 8;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic       led;
    logic [3:0] count;
    logic       active;
  } led_status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic req_type_i = 1'b0;
  logic [CODE_W-1:0] action_code_i = '0;
  logic signed [REP_IN_W-1:0] repeat_count_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic led_level_o;
  logic [COUNT_OUT_W-1:0] queue_count_o;
  logic pattern_active_o;

  led_pattern_queue_sequencer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .action_code_i   (action_code_i),
    .repeat_count_i  (repeat_count_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .led_level_o     (led_level_o),
    .queue_count_o   (queue_count_o),
    .pattern_active_o(pattern_active_o)
  );

  always #6 clk_i = ~clk_i;

  cmd_t        pending_reqs[$];
  cmd_t        held_req;
  led_status_t predicted_status[$];
  bit          req_accepted = 1'b0;
  bit          steady = 1'b0;
  int          fail_count = 0;
  int          cycle_count = 0;

  // sequencer state as the bench sees it
  bit          cfg_active = 1'b1;
  int unsigned cfg_on = 10;
  int unsigned cfg_slow_off = 190;
  int unsigned cfg_once_off = 40;
  logic [CODE_W-1:0] q_code [DEPTH] = '{default: '0};
  int          q_reps [DEPTH] = '{default: 0};
  int unsigned head = 0, tail = 0, fill = 0, cur_slot = 0, countdown = 0;
  bit          rearm = 0, running = 0, lit_phase = 0, holding = 0, pin = 0;

  function automatic int unsigned wrap_next(int unsigned p);
    return (p + 1 >= DEPTH) ? 0 : p + 1;
  endfunction

  function automatic void enter_phase();
    int unsigned slot;
    logic [CODE_W-1:0] code;
    bit lit, hold, stop, nphase;
    int unsigned dur;
    slot = cur_slot % DEPTH;
    code = q_code[slot];
    lit = 0;
    hold = 0;
    stop = 0;
    nphase = 0;
    dur = 0;
    case (code)
      ACT_OFF: hold = 1;
      ACT_ON: begin
        lit = 1;
        hold = 1;
      end
      ACT_SLOW, ACT_ANGRY, ACT_ONCE: begin
        if (lit_phase) begin
          dur = (code == ACT_SLOW) ? cfg_slow_off : (code == ACT_ANGRY) ? cfg_on : cfg_once_off;
          if (q_reps[slot] >= 0) begin
            q_reps[slot]--;
            if (q_reps[slot] < 0) stop = 1;
          end
        end else begin
          lit = 1;
          dur = cfg_on;
          nphase = 1;
        end
      end
      default: begin
        // unknown action gets dropped while the queue holds entries
        if (fill > 0) begin
          stop = 1;
          head = wrap_next(head);
          fill--;
        end else begin
          hold = 1;
        end
      end
    endcase
    rearm = stop;
    if (stop) begin
      running = 0;
    end else begin
      countdown = dur;
      lit_phase = nphase;
      holding = hold;
      pin = lit ? cfg_active : !cfg_active;
    end
  endfunction

  function automatic void restart_sequence();
    if (fill == 0) return;
    // leading forever entries go while more follow
    while (fill > 1 && q_reps[head] < 0) begin
      fill--;
      head = wrap_next(head);
    end
    cur_slot = head;
    running = 1;
    lit_phase = 0;
    enter_phase();
  endfunction

  function automatic led_status_t predict_status(cmd_t c);
    led_status_t r;
    int reps;
    if (c.kind == CMD_PUSH) begin
      reps = $signed(c.repeat_count);
      q_code[tail] = c.action_code;
      q_reps[tail] = reps;
      tail = wrap_next(tail);
      if (fill < DEPTH) begin
        fill++;
      end else begin
        head = wrap_next(head);
        running = 0;
      end
      rearm = 1;
    end else if (rearm) begin
      restart_sequence();
    end else if (running && !holding) begin
      if (countdown <= 1) enter_phase();
      else countdown--;
    end
    r.led = pin;
    r.count = 4'(fill);
    r.active = running;
    return r;
  endfunction

  always @(negedge clk_i) begin : drive_requests
    if (!in_valid_i || req_accepted) begin
      if (pending_reqs.size() != 0 && (steady || $urandom_range(0, 99) >= 9)) begin
        held_req = pending_reqs.pop_front();
        in_valid_i     <= 1'b1;
        req_type_i     <= held_req.kind;
        action_code_i  <= held_req.action_code;
        repeat_count_i <= held_req.repeat_count;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= !steady && ($urandom_range(0, 99) < 9);
  end

  always @(posedge clk_i) begin : check_results
    led_status_t want;
    cycle_count++;
    req_accepted = rst_ni && in_valid_i && !in_stall_o;
    if (req_accepted) predicted_status.push_back(predict_status(held_req));
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_status.size() == 0) begin
        $display("%0t: result with no request waiting, expected none, got led %0d count %0d active %0d",
                 $time, led_level_o, queue_count_o, pattern_active_o);
        fail_count++;
      end else begin
        want = predicted_status.pop_front();
        if (led_level_o !== want.led) begin
          $display("%0t: led_level expected %0d, got %0d", $time, want.led, led_level_o);
          fail_count++;
        end
        if (queue_count_o !== want.count) begin
          $display("%0t: queue_count expected %0d, got %0d", $time, want.count, queue_count_o);
          fail_count++;
        end
        if (pattern_active_o !== want.active) begin
          $display("%0t: pattern_active expected %0d, got %0d",
                   $time, want.active, pattern_active_o);
          fail_count++;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void add_push(logic [CODE_W-1:0] code, int reps);
    cmd_t c;
    c.kind = CMD_PUSH;
    c.action_code = code;
    c.repeat_count = 16'(reps);
    pending_reqs.push_back(c);
  endfunction

  function automatic void add_tick();
    cmd_t c;
    c.kind = CMD_TICK;
    c.action_code = 3'($urandom);
    c.repeat_count = 16'($urandom);
    pending_reqs.push_back(c);
  endfunction

  function automatic void add_random_push();
    int p;
    int reps;
    p = $urandom_range(0, 99);
    if (p < 60) reps = $urandom_range(0, 3);
    else if (p < 75) reps = -1;
    else if (p < 85) reps = $signed(16'($urandom));
    else reps = $urandom_range(4, 20);
    if ($urandom_range(0, 99) < 12) add_push(3'($urandom_range(5, 7)), reps);
    else add_push(3'($urandom_range(0, 4)), reps);
  endfunction

  function automatic void add_random_requests(int total);
    int n;
    int p;
    int burst;
    n = 0;
    while (n < total) begin
      p = $urandom_range(0, 99);
      if (p < 4) begin
        // enough pushes to wrap a full queue
        burst = $urandom_range(8, 11);
        for (int i = 0; i < burst; i++) add_random_push();
        n += burst;
      end else if (p < 28) begin
        add_random_push();
        n++;
      end else begin
        add_tick();
        n++;
      end
    end
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid_i || predicted_status.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_settings(logic act, logic [15:0] on, logic [15:0] slow_off,
                                logic [15:0] once_off);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{CFG_ACTIVE_LEVEL, CFG_ON_TICKS, CFG_SLOW_OFF_TICKS, CFG_ONCE_OFF_TICKS};
    val = '{16'(act), on, slow_off, once_off};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx[i];
      cfg_wdata_i <= val[i];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_active = act;
    cfg_on = on;
    cfg_slow_off = slow_off;
    cfg_once_off = once_off;
  endtask

  int unsigned phase_cfg [7][4] = '{
    '{1, 1, 1, 1},
    '{0, 2, 3, 1},
    '{1, 0, 0, 0},
    '{0, 65535, 65535, 65535},
    '{1, 3, 5, 2},
    '{0, 1, 4, 65535},
    '{1, 2, 1, 3}
  };
  int phase_len [7] = '{85, 85, 85, 30, 85, 85, 90};

  initial begin : run_phases
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, empty queue tick
    add_tick();
    add_push(ACT_ANGRY, 0);
    add_tick();
    add_tick();
    wait_drained();

    write_settings(1'b0, 16'd1, 16'd2, 16'd1);
    add_push(ACT_OFF, -1);
    add_push(ACT_ON, 32767);
    add_tick();
    add_push(3'd5, -32768);
    add_push(ACT_SLOW, 0);
    repeat (5) add_tick();
    add_push(ACT_ONCE, 1);
    add_push(3'd6, 0);
    add_push(3'd7, -1);
    add_push(ACT_ANGRY, -2);
    add_push(ACT_ON, 0);
    repeat (5) add_tick();
    wait_drained();

    for (int ph = 0; ph < 7; ph++) begin
      write_settings(phase_cfg[ph][0][0], 16'(phase_cfg[ph][1]), 16'(phase_cfg[ph][2]),
                     16'(phase_cfg[ph][3]));
      steady = (ph == 6);
      add_random_requests(phase_len[ph]);
      wait_drained();
    end

    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && predicted_status.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: filelist.f
design/lpqs_pkg.sv
design/lpqs_ram.sv
design/lpqs_front.sv
design/lpqs_back.sv
design/led_pattern_queue_sequencer.sv
bench/led_pattern_queue_sequencer_test.sv
